>>> rtl/lzwcew_pkg.sv
`timescale 1ns / 1ps

package lzwcew_pkg;

   localparam int CODE_W   = 12;
   localparam int WIDTH_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_CODE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code_out;
      logic [WIDTH_W-1:0]  code_width;
      logic [STATUS_W-1:0] status;
      logic                run_end;
      logic                stream_end;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_RUN,
      PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      EK_ESC,
      EK_CODE,
      EK_SHORT,
      EK_FULL
   } emit_kind_type;

   typedef struct packed {
      logic          load_in;
      logic          clear_step;
      logic          probe_start;
      logic          probe_next;
      logic          insert;
      logic          set_first;
      logic          set_found;
      logic          load_emit_prefix;
      logic          load_emit_byte;
      logic          load_emit_found;
      logic          after_main;
      logic          set_failed;
      logic          end_stream;
      logic          emit;
      emit_kind_type emit_kind;
      logic          run_end;
      logic          stream_end;
   } dp_cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      last;
      logic      hit;
      logic      empty;
      logic      full;
      logic      found_ok;
      logic      prefix_ok;
      logic      esc_now;
      logic      rsp_free;
      logic      clear_done;
   } dp_status_type;

endpackage

>>> rtl/lzwcew_dp.sv
`timescale 1ns / 1ps

module lzwcew_dp
   import lzwcew_pkg::*;
#(
   parameter int MAX_WIDTH       = 12,
   parameter int MIN_WIDTH       = 9,
   parameter int FIRST_FREE_CODE = 256,
   parameter int DICT_SIZE       = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_word,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_word,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   localparam int CW  = $clog2(DICT_SIZE);
   localparam int TW  = CW + 1;
   localparam int NW  = CW + 1;
   localparam int KW  = CW + 8;
   localparam int DW  = KW + TW;
   localparam int TBL = 1 << TW;

   logic [7:0]    byte_ff;
   logic          last_ff;
   logic [CW-1:0] prefix_ff;
   logic [NW-1:0] next_ff;
   logic [4:0]    cur_ff;
   phase_type     phase_ff;
   logic [CW-1:0] emit_ff;
   logic [TW-1:0] idx_ff;
   logic [TW-1:0] clr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_word_ff;
   rsp_type       rsp_word_in;

   // hash slots hold codes, dictionary holds key and owning slot per code
   logic [CW-1:0] hash_mem [TBL];
   logic [DW-1:0] dict_mem [DICT_SIZE];
   logic [CW-1:0] tbl_q_ff;
   logic [DW-1:0] dict_q_ff;

   logic [KW-1:0] key_w;
   logic [TW-1:0] hash_w;
   logic          owned_w;
   logic [16:0]   esc_val_w;

   function automatic logic esc_hit(input logic [CW-1:0] code, input logic [4:0] w);
      esc_hit = (w < 5'(MAX_WIDTH)) && (17'(code) >= ((17'd1 << w) - 17'd1));
   endfunction

   function automatic logic [2:0] esc_count(input logic [CW-1:0] code,
                                            input logic [4:0] cur);
      logic [4:0] w;
      logic       run;
      logic [2:0] e;
      w   = cur;
      run = 1'b1;
      e   = 3'd0;
      for (int k = 0; k < 7; k++) begin
         if (run && esc_hit(code, w)) begin
            e = e + 3'd1;
            w = w + 5'd1;
         end else begin
            run = 1'b0;
         end
      end
      return e;
   endfunction

   assign key_w     = {prefix_ff, byte_ff};
   assign hash_w    = {byte_ff, {(TW-8){1'b0}}} ^ TW'(prefix_ff);
   assign esc_val_w = (17'd1 << cur_ff) - 17'd1;

   // a slot counts only if its code is live and the code points back at it
   assign owned_w = (NW'(tbl_q_ff) >= NW'(FIRST_FREE_CODE)) && (NW'(tbl_q_ff) < next_ff)
                    && (dict_q_ff[TW-1:0] == idx_ff);

   always_comb begin
      status.phase      = phase_ff;
      status.last       = last_ff;
      status.hit        = owned_w && (dict_q_ff[DW-1:TW] == key_w);
      status.empty      = !owned_w;
      status.full       = next_ff >= NW'(DICT_SIZE);
      status.found_ok   = esc_count(tbl_q_ff, cur_ff) <= 3'd2;
      status.prefix_ok  = esc_count(prefix_ff, cur_ff) <= (last_ff ? 3'd1 : 3'd2);
      status.esc_now    = esc_hit(emit_ff, cur_ff);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
      status.clear_done = &clr_ff;
   end

   always_comb begin
      rsp_word_in.code_width = WIDTH_W'(cur_ff);
      rsp_word_in.run_end    = cmd.run_end;
      rsp_word_in.stream_end = cmd.stream_end;
      case (cmd.emit_kind)
         EK_ESC: begin
            rsp_word_in.code_out = CODE_W'(esc_val_w);
            rsp_word_in.status   = ST_CODE;
         end
         EK_CODE: begin
            rsp_word_in.code_out = CODE_W'(emit_ff);
            rsp_word_in.status   = ST_CODE;
         end
         EK_SHORT: begin
            rsp_word_in.code_out = '0;
            rsp_word_in.status   = ST_SHORT;
         end
         default: begin
            rsp_word_in.code_out = '0;
            rsp_word_in.status   = ST_FULL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.end_stream) begin
         prefix_ff <= '0;
         next_ff   <= NW'(FIRST_FREE_CODE);
         cur_ff    <= 5'(MIN_WIDTH);
         phase_ff  <= PH_FIRST;
      end else begin
         if (cmd.set_first || cmd.after_main) begin
            prefix_ff <= CW'(byte_ff);
         end else if (cmd.set_found) begin
            prefix_ff <= tbl_q_ff;
         end
         if (cmd.insert) begin
            next_ff <= next_ff + NW'(1);
         end
         if (cmd.emit && cmd.emit_kind == EK_ESC) begin
            cur_ff <= cur_ff + 5'd1;
         end
         if (cmd.set_first) begin
            phase_ff <= PH_SECOND;
         end else if (cmd.after_main) begin
            phase_ff <= PH_RUN;
         end else if (cmd.set_failed) begin
            phase_ff <= PH_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + TW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         byte_ff <= req_word.byte_in;
         last_ff <= req_word.last_byte;
      end
      if (cmd.load_emit_prefix) begin
         emit_ff <= prefix_ff;
      end else if (cmd.load_emit_byte) begin
         emit_ff <= CW'(byte_ff);
      end else if (cmd.load_emit_found) begin
         emit_ff <= tbl_q_ff;
      end
      if (cmd.probe_start) begin
         idx_ff <= hash_w;
      end else if (cmd.probe_next) begin
         idx_ff <= idx_ff + TW'(1);
      end
      if (cmd.emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      tbl_q_ff  <= hash_mem[idx_ff];
      dict_q_ff <= dict_mem[tbl_q_ff];
      if (cmd.clear_step) begin
         hash_mem[clr_ff] <= '0;
      end else if (cmd.insert) begin
         hash_mem[idx_ff] <= next_ff[CW-1:0];
      end
      if (cmd.insert) begin
         dict_mem[next_ff[CW-1:0]] <= {key_w, idx_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> rtl/lzwcew_ctrl.sv
`timescale 1ns / 1ps

module lzwcew_ctrl
   import lzwcew_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_SHORT,
      S_PROBE_A,
      S_PROBE_B,
      S_PROBE_C,
      S_EMIT1,
      S_EMIT2,
      S_FAIL,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_kind = EK_CODE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.phase)
               PH_FIRST: state_in = S_SHORT;
               PH_FAIL:  state_in = S_FINISH;
               default: begin
                  cmd.probe_start = 1'b1;
                  state_in        = S_PROBE_A;
               end
            endcase
         end
         S_SHORT: begin
            if (!status.last) begin
               cmd.set_first = 1'b1;
               state_in      = S_IDLE;
            end else if (status.rsp_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_kind  = EK_SHORT;
               cmd.run_end    = 1'b1;
               cmd.stream_end = 1'b1;
               state_in       = S_FINISH;
            end
         end
         S_PROBE_A: state_in = S_PROBE_B;
         S_PROBE_B: state_in = S_PROBE_C;
         S_PROBE_C: begin
            if (status.hit) begin
               if (!status.last) begin
                  cmd.set_found = 1'b1;
                  state_in      = S_FINISH;
               end else if (status.found_ok) begin
                  cmd.set_found       = 1'b1;
                  cmd.load_emit_found = 1'b1;
                  state_in            = S_EMIT2;
               end else begin
                  state_in = S_FAIL;
               end
            end else if (status.empty) begin
               if (status.full || !status.prefix_ok) begin
                  state_in = S_FAIL;
               end else begin
                  cmd.insert           = 1'b1;
                  cmd.load_emit_prefix = 1'b1;
                  state_in             = S_EMIT1;
               end
            end else begin
               // slot taken by another key, step to the next one
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE_A;
            end
         end
         S_EMIT1: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.esc_now) begin
                  cmd.emit_kind = EK_ESC;
               end else begin
                  cmd.run_end    = !status.last;
                  cmd.after_main = 1'b1;
                  if (status.last) begin
                     cmd.load_emit_byte = 1'b1;
                     state_in           = S_EMIT2;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_EMIT2: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.esc_now) begin
                  cmd.emit_kind = EK_ESC;
               end else begin
                  cmd.run_end    = 1'b1;
                  cmd.stream_end = status.last;
                  state_in       = S_FINISH;
               end
            end
         end
         S_FAIL: begin
            if (status.rsp_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_kind  = EK_FULL;
               cmd.run_end    = 1'b1;
               cmd.stream_end = status.last;
               cmd.set_failed = 1'b1;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.end_stream = status.last;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

>>> rtl/lzw_compressor_escape_width_top.sv
`timescale 1ns / 1ps

// lzw compressor with escape-coded code width growth.
// req channel: one raw byte per word plus last_byte, which ends the stream and
// flushes the pending prefix. rsp channel: zero to three words per byte, each a
// code or escape with its width, or an error status; run_end marks the final
// word of a byte and stream_end the final word of a stream.
// the dictionary sits in a hashed slot memory of 2*DICT_SIZE entries backed by
// a code-indexed pair memory; each probe steps through a slot read, a pair
// read and a compare. bytes are handled one at a time.
// req_ready rises only between bytes; the response register lets the next byte
// be taken while the last word waits. a stalled receiver holds the block in its
// emit step until the pending word is taken.
// after reset the slot memory is swept clean with req_ready low. at the end
// of each stream all stream state returns to its reset value; stale
// dictionary contents are ignored without a sweep.
module lzw_compressor_escape_width_top
   import lzwcew_pkg::*;
#(
   parameter int MAX_WIDTH       = 12,
   parameter int MIN_WIDTH       = 9,
   parameter int FIRST_FREE_CODE = 256,
   parameter int DICT_SIZE       = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   dp_cmd_type    cmd;
   dp_status_type status;

   lzwcew_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lzwcew_dp #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MIN_WIDTH       (MIN_WIDTH),
      .FIRST_FREE_CODE (FIRST_FREE_CODE),
      .DICT_SIZE       (DICT_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .status    (status)
   );

   a_stream_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.stream_end |-> rsp_word.run_end)
      else $error("stream_end without run_end");

   a_error_has_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_CODE |-> rsp_word.code_out == '0)
      else $error("error word carries a code");

   a_one_byte_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("byte taken while another is in work");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("response word overwritten");

endmodule

>>> test/tb_lzw_compressor_escape_width_top.sv
`timescale 1ns / 1ps

module tb_lzw_compressor_escape_width_top;
   import lzwcew_pkg::*;

   localparam int MAX_W     = 12;
   localparam int MIN_W     = 9;
   localparam int FIRST_NEW = 256;
   localparam int DICT_N    = 4096;
   localparam int SLOT_N    = 3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_word;

   lzw_compressor_escape_width_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   // bytes waiting to be sent, with the idling mode of each
   req_type   byte_queue[$];
   int        mode_queue[$];
   rsp_type   expected_codes[$];
   int        cur_mode;
   int        mismatches;

   // compressor state mirror
   int        dict_code[int];
   int        prefix;
   int        next_free;
   int        width;
   phase_type phase;
   rsp_type   step_out[$];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_stream();
      dict_code.delete();
      prefix    = 0;
      next_free = FIRST_NEW;
      width     = MIN_W;
      phase     = PH_FIRST;
   endfunction

   function automatic void put_word(int code, logic [STATUS_W-1:0] st);
      rsp_type r;
      r.code_out   = code[CODE_W-1:0];
      r.code_width = width[WIDTH_W-1:0];
      r.status     = st;
      r.run_end    = 0;
      r.stream_end = 0;
      step_out.push_back(r);
   endfunction

   // sends code preceded by escapes for each width step it crosses
   function automatic bit send_with_escapes(int code, int limit);
      int w;
      int e;
      w = width;
      e = 0;
      while (w < MAX_W && code >= (1 << w) - 1) begin
         e++;
         w++;
      end
      if (step_out.size() + e + 1 > limit) return 0;
      repeat (e) begin
         put_word((1 << width) - 1, ST_CODE);
         width++;
      end
      put_word(code, ST_CODE);
      return 1;
   endfunction

   function automatic void go_full();
      put_word(0, ST_FULL);
      phase = PH_FAIL;
   endfunction

   function automatic void add_pair(int pre, int suf);
      if (next_free < DICT_N) begin
         dict_code[(pre << 8) | suf] = next_free;
         next_free++;
      end
   endfunction

   function automatic void compress_byte(req_type w);
      int  b;
      int  key;
      bit  last;
      b    = w.byte_in;
      last = w.last_byte;
      key  = (prefix << 8) | b;
      step_out.delete();
      case (phase)
         PH_FIRST: begin
            prefix = b;
            phase  = PH_SECOND;
            if (last) put_word(0, ST_SHORT);
         end
         PH_SECOND: begin
            add_pair(prefix, b);
            put_word(prefix, ST_CODE);
            prefix = b;
            phase  = PH_RUN;
            if (last && !send_with_escapes(prefix, SLOT_N)) go_full();
         end
         PH_RUN: begin
            if (dict_code.exists(key)) begin
               prefix = dict_code[key];
               if (last && !send_with_escapes(prefix, SLOT_N)) go_full();
            end else if (next_free >= DICT_N) begin
               go_full();
            end else if (!send_with_escapes(prefix, last ? SLOT_N - 1 : SLOT_N)) begin
               go_full();
            end else begin
               add_pair(prefix, b);
               prefix = b;
               if (last && !send_with_escapes(prefix, SLOT_N)) go_full();
            end
         end
         default: ;
      endcase
      if (step_out.size() > 0) begin
         step_out[step_out.size() - 1].run_end = 1;
         if (last) step_out[step_out.size() - 1].stream_end = 1;
      end
      foreach (step_out[i]) expected_codes.push_back(step_out[i]);
      if (last) clear_stream();
   endfunction

   function automatic bit idle_now(bit sender);
      case (cur_mode)
         0: return sender ? ($urandom_range(0, 99) < 24) : ($urandom_range(0, 99) < 85);
         1: return sender ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 24);
         default: return 0;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_word  <= '0;
      end else begin
         if (req_valid && req_ready) compress_byte(req_word);
         if (!req_valid || req_ready) begin
            if (byte_queue.size() > 0) cur_mode = mode_queue[0];
            if (byte_queue.size() > 0 && !idle_now(1)) begin
               req_word  <= byte_queue.pop_front();
               void'(mode_queue.pop_front());
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: code %0d width %0d status %0d run %0b end %0b",
                           rsp_word.code_out, rsp_word.code_width, rsp_word.status,
                           rsp_word.run_end, rsp_word.stream_end);
            end else begin
               rsp_type e;
               e = expected_codes.pop_front();
               if (rsp_word.code_out !== e.code_out || rsp_word.code_width !== e.code_width
                   || rsp_word.status !== e.status || rsp_word.run_end !== e.run_end
                   || rsp_word.stream_end !== e.stream_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp code %0d w %0d st %0d run %0b end %0b",
                              e.code_out, e.code_width, e.status, e.run_end, e.stream_end,
                              ", got code %0d w %0d st %0d run %0b end %0b",
                              rsp_word.code_out, rsp_word.code_width, rsp_word.status,
                              rsp_word.run_end, rsp_word.stream_end);
               end
            end
         end
         rsp_ready <= !idle_now(0);
      end
   end

   task automatic add_byte(int b, bit last, int mode);
      req_type w;
      w.byte_in   = b[7:0];
      w.last_byte = last;
      byte_queue.push_back(w);
      mode_queue.push_back(mode);
   endtask

   initial begin
      int len;
      int alpha;
      int mode;
      int count;
      mismatches = 0;
      cur_mode   = 2;
      clear_stream();
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;

      // single-byte streams at both byte extremes
      add_byte(8'hff, 1, 0);
      add_byte(8'h00, 1, 0);
      // two-byte stream
      add_byte(8'h00, 0, 0);
      add_byte(8'hff, 1, 0);
      // repeats so lookups hit, flush of a dictionary code
      repeat (7) add_byte(8'h41, 0, 0);
      add_byte(8'h41, 1, 0);
      // mixed stream ending on a miss
      add_byte(8'h55, 0, 0);
      add_byte(8'haa, 0, 0);
      add_byte(8'h55, 0, 0);
      add_byte(8'haa, 0, 0);
      add_byte(8'h55, 0, 0);
      add_byte(8'h01, 1, 0);

      // random short streams, small alphabets give dictionary hits
      count = 0;
      while (count < 300) begin
         mode  = count < 100 ? 0 : (count < 200 ? 1 : 2);
         len   = $urandom_range(1, 30);
         alpha = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 4);
         for (int i = 0; i < len; i++)
            add_byte(($urandom_range(0, 3) == 0 && alpha == 255) ? $urandom_range(0, 255) :
                     ($urandom_range(0, alpha) ^ (alpha == 255 ? 0 : 8'h80)),
                     i == len - 1, mode);
         count += len;
      end

      // one longer stream of random bytes
      for (int i = 0; i < 100; i++) add_byte($urandom_range(0, 255), 0, 2);
      add_byte($urandom_range(0, 255), 1, 2);
      // stream after a long one must start clean
      add_byte(8'h12, 0, 2);
      add_byte(8'h34, 1, 2);

      wait (byte_queue.size() == 0 && !req_valid);
      @(posedge clock);
      wait (expected_codes.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_codes.size() == 0) begin
         $display("tb_lzw_compressor_escape_width_top OK");
      end else begin
         $display("tb_lzw_compressor_escape_width_top NOT OK");
      end
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("tb_lzw_compressor_escape_width_top NOT OK");
      $finish;
   end

endmodule
